@@ hw/rtl/lsci_pkg.sv @@
// lsci_pkg: types and constants shared by the LCD serial command interpreter.
// Parse states, command codes, bus codes and the job word passed front to back.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lsci_pkg;

    typedef enum logic [4:0] {
        ST_IDLE       = 5'd0,
        ST_CMD        = 5'd1,
        ST_COL        = 5'd2,
        ST_ROW        = 5'd3,
        ST_GLYPH_0    = 5'd4,
        ST_GLYPH_1    = 5'd5,
        ST_GLYPH_2    = 5'd6,
        ST_GLYPH_3    = 5'd7,
        ST_GLYPH_4    = 5'd8,
        ST_GLYPH_5    = 5'd9,
        ST_GLYPH_6    = 5'd10,
        ST_GLYPH_7    = 5'd11,
        ST_GLYPH_LAST = 5'd12,
        ST_CONTRAST   = 5'd13,
        ST_BRIGHT     = 5'd14,
        ST_SKIP2      = 5'd15,
        ST_SKIP1      = 5'd16
    } lsci_state_t;

    localparam logic [7:0] PREFIX_BYTE      = 8'd254;
    localparam logic [7:0] CMD_BL_ON        = 8'd66;
    localparam logic [7:0] CMD_BL_OFF       = 8'd70;
    localparam logic [7:0] CMD_GOTO         = 8'd71;
    localparam logic [7:0] CMD_HOME         = 8'd72;
    localparam logic [7:0] CMD_GLYPH        = 8'd78;
    localparam logic [7:0] CMD_CONTRAST     = 8'd80;
    localparam logic [7:0] CMD_GPO_OFF      = 8'd86;
    localparam logic [7:0] CMD_GPO_ON       = 8'd87;
    localparam logic [7:0] CMD_CLEAR        = 8'd88;
    localparam logic [7:0] CMD_GPO_PWM      = 8'd102;
    localparam logic [7:0] CMD_CONTRAST_ALT = 8'd145;
    localparam logic [7:0] CMD_BRIGHT       = 8'd152;
    localparam logic [7:0] CMD_BRIGHT_ALT   = 8'd153;

    localparam logic [7:0] ROW_1 = 8'd1;
    localparam logic [7:0] ROW_2 = 8'd2;
    localparam logic [7:0] ROW_3 = 8'd3;
    localparam logic [7:0] ROW_4 = 8'd4;

    localparam logic [7:0] ROW_BASE_ODD  = 8'd127;
    localparam logic [7:0] ROW_BASE_EVEN = 8'd191;
    localparam logic [7:0] HOME_ADDR     = 8'd128;
    localparam logic [7:0] CGRAM_BASE    = 8'd64;
    localparam logic [7:0] FUNCTION_SET  = 8'h3C;

    localparam logic [7:0] CONTRAST_RESET  = 8'd0;
    localparam logic [7:0] BACKLIGHT_RESET = 8'd255;
    localparam logic [7:0] BL_ON_RESET     = 8'd128;
    localparam logic [7:0] BACKLIGHT_OFF   = 8'd0;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_INST = 2'd1;
    localparam logic [1:0] KIND_DATA = 2'd2;

    localparam logic [1:0] MASK_NONE  = 2'd0;
    localparam logic [1:0] MASK_UPPER = 2'd1;
    localparam logic [1:0] MASK_LOWER = 2'd2;
    localparam logic [1:0] MASK_BOTH  = 2'd3;

    localparam int         JOB_WORDS = 9;
    localparam logic [3:0] GLYPH_RUN = 4'd9;
    localparam logic [3:0] BRIGHT_RUN = 4'd2;
    localparam logic [3:0] SINGLE_RUN = 4'd1;

    // first word uses first_kind, the rest are data writes
    typedef struct packed {
        logic [1:0]                 first_kind;
        logic [1:0]                 mask;
        logic [3:0]                 count;
        logic [JOB_WORDS-1:0][7:0]  data;
        logic [7:0]                 contrast;
        logic [7:0]                 backlight;
    } lsci_job_t;

endpackage

`default_nettype wire

@@ hw/rtl/lsci_front.sv @@
// lsci_front: byte parser. Holds parse state, cursor, glyph buffer, PWM levels.
// Turns each accepted byte into one job word. Uses lsci_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsci_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire logic [7:0]         rx_byte,
    input  wire logic               cfg_we,
    input  wire logic [7:0]         cfg_data,
    output lsci_pkg::lsci_job_t     job
);

    lsci_pkg::lsci_state_t state_reg, state_next;
    logic [1:0] target_reg, target_next;
    logic [7:0] cursor_reg, cursor_next;
    logic [7:0] column_reg, column_next;
    logic [7:0] contrast_reg, contrast_next;
    logic [7:0] backlight_reg, backlight_next;
    logic [7:0] bl_on_reg;
    logic [7:0] glyph_reg [8];
    logic       glyph_we;
    logic [2:0] glyph_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lsci_pkg::ST_IDLE;
            target_reg    <= lsci_pkg::MASK_UPPER;
            cursor_reg    <= '0;
            column_reg    <= '0;
            contrast_reg  <= lsci_pkg::CONTRAST_RESET;
            backlight_reg <= lsci_pkg::BACKLIGHT_RESET;
        end
        else if (accept)
        begin
            state_reg     <= state_next;
            target_reg    <= target_next;
            cursor_reg    <= cursor_next;
            column_reg    <= column_next;
            contrast_reg  <= contrast_next;
            backlight_reg <= backlight_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bl_on_reg <= lsci_pkg::BL_ON_RESET;
        end
        else if (cfg_we)
        begin
            bl_on_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && glyph_we)
        begin
            glyph_reg[glyph_idx] <= rx_byte;
        end
    end

    always_comb
    begin
        state_next     = lsci_pkg::ST_IDLE;
        target_next    = target_reg;
        cursor_next    = cursor_reg;
        column_next    = column_reg;
        contrast_next  = contrast_reg;
        backlight_next = backlight_reg;
        glyph_we       = 1'b0;
        glyph_idx      = 3'(state_reg - lsci_pkg::ST_GLYPH_0);
        job            = '0;
        job.first_kind = lsci_pkg::KIND_NONE;
        job.mask       = lsci_pkg::MASK_NONE;
        job.count      = lsci_pkg::SINGLE_RUN;

        case (state_reg)
            lsci_pkg::ST_IDLE:
            begin
                if (rx_byte == lsci_pkg::PREFIX_BYTE)
                begin
                    state_next = lsci_pkg::ST_CMD;
                end
                else
                begin
                    job.first_kind = lsci_pkg::KIND_DATA;
                    job.mask       = target_reg;
                    job.data[0]    = rx_byte;
                end
            end
            lsci_pkg::ST_CMD:
            begin
                case (rx_byte)
                    lsci_pkg::CMD_HOME, lsci_pkg::CMD_CLEAR:
                    begin
                        target_next    = lsci_pkg::MASK_UPPER;
                        job.first_kind = lsci_pkg::KIND_INST;
                        job.mask       = lsci_pkg::MASK_UPPER;
                        job.data[0]    = lsci_pkg::HOME_ADDR;
                    end
                    lsci_pkg::CMD_BL_ON:
                    begin
                        backlight_next = bl_on_reg;
                        state_next     = lsci_pkg::ST_SKIP1;
                    end
                    lsci_pkg::CMD_BL_OFF:
                    begin
                        backlight_next = lsci_pkg::BACKLIGHT_OFF;
                    end
                    lsci_pkg::CMD_GOTO:
                    begin
                        state_next = lsci_pkg::ST_COL;
                    end
                    lsci_pkg::CMD_GLYPH:
                    begin
                        state_next = lsci_pkg::ST_GLYPH_0;
                    end
                    lsci_pkg::CMD_CONTRAST, lsci_pkg::CMD_CONTRAST_ALT:
                    begin
                        state_next = lsci_pkg::ST_CONTRAST;
                    end
                    lsci_pkg::CMD_GPO_OFF, lsci_pkg::CMD_GPO_ON:
                    begin
                        state_next = lsci_pkg::ST_SKIP1;
                    end
                    lsci_pkg::CMD_GPO_PWM:
                    begin
                        state_next = lsci_pkg::ST_SKIP2;
                    end
                    lsci_pkg::CMD_BRIGHT, lsci_pkg::CMD_BRIGHT_ALT:
                    begin
                        state_next = lsci_pkg::ST_BRIGHT;
                    end
                    default:
                    begin
                        state_next = lsci_pkg::ST_IDLE;
                    end
                endcase
            end
            lsci_pkg::ST_COL:
            begin
                column_next = rx_byte;
                state_next  = lsci_pkg::ST_ROW;
            end
            lsci_pkg::ST_ROW:
            begin
                case (rx_byte)
                    lsci_pkg::ROW_1:
                    begin
                        cursor_next = lsci_pkg::ROW_BASE_ODD;
                        target_next = lsci_pkg::MASK_UPPER;
                    end
                    lsci_pkg::ROW_2:
                    begin
                        cursor_next = lsci_pkg::ROW_BASE_EVEN;
                        target_next = lsci_pkg::MASK_UPPER;
                    end
                    lsci_pkg::ROW_3:
                    begin
                        cursor_next = lsci_pkg::ROW_BASE_ODD;
                        target_next = lsci_pkg::MASK_LOWER;
                    end
                    lsci_pkg::ROW_4:
                    begin
                        cursor_next = lsci_pkg::ROW_BASE_EVEN;
                        target_next = lsci_pkg::MASK_LOWER;
                    end
                    default:
                    begin
                        cursor_next = cursor_reg;
                    end
                endcase
                cursor_next    = cursor_next + column_reg;
                job.first_kind = lsci_pkg::KIND_INST;
                job.mask       = target_next;
                job.data[0]    = cursor_next;
            end
            lsci_pkg::ST_GLYPH_0, lsci_pkg::ST_GLYPH_1, lsci_pkg::ST_GLYPH_2,
            lsci_pkg::ST_GLYPH_3, lsci_pkg::ST_GLYPH_4, lsci_pkg::ST_GLYPH_5,
            lsci_pkg::ST_GLYPH_6, lsci_pkg::ST_GLYPH_7:
            begin
                glyph_we   = 1'b1;
                state_next = lsci_pkg::lsci_state_t'(5'(state_reg + 5'd1));
            end
            lsci_pkg::ST_GLYPH_LAST:
            begin
                job.first_kind = lsci_pkg::KIND_INST;
                job.mask       = lsci_pkg::MASK_BOTH;
                job.count      = lsci_pkg::GLYPH_RUN;
                job.data[0]    = lsci_pkg::CGRAM_BASE + {glyph_reg[0][4:0], 3'b000};
                for (int i = 1; i < 8; i++)
                begin
                    job.data[i] = glyph_reg[i];
                end
                job.data[8]    = rx_byte;
            end
            lsci_pkg::ST_CONTRAST:
            begin
                contrast_next = ~rx_byte;
            end
            lsci_pkg::ST_BRIGHT:
            begin
                backlight_next = rx_byte;
                job.first_kind = lsci_pkg::KIND_INST;
                job.mask       = lsci_pkg::MASK_BOTH;
                job.count      = lsci_pkg::BRIGHT_RUN;
                job.data[0]    = lsci_pkg::FUNCTION_SET;
                job.data[1]    = {6'b000000, ~rx_byte[7:6]};
            end
            lsci_pkg::ST_SKIP2:
            begin
                state_next = lsci_pkg::ST_SKIP1;
            end
            lsci_pkg::ST_SKIP1:
            begin
                state_next = lsci_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lsci_pkg::ST_IDLE;
            end
        endcase

        job.contrast  = contrast_next;
        job.backlight = backlight_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/lsci_queue.sv @@
// lsci_queue: short job queue between parser front and bus-write back end.
// Uses lsci_pkg for the job word.
`timescale 1ns / 1ps
`default_nettype none

module lsci_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire lsci_pkg::lsci_job_t wr_job,
    output logic                     full,
    input  wire logic                rd_en,
    output logic                     rd_valid,
    output lsci_pkg::lsci_job_t      rd_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    lsci_pkg::lsci_job_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == FULL_CNT);
    assign rd_valid = (count_reg != '0);
    assign rd_job   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !(rd_en && rd_valid))
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!wr_en && rd_en && rd_valid)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (rd_en && rd_valid)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/lsci_back.sv @@
// lsci_back: expands the head job into bus-write words, one per cycle
// when the output register is free or popped. Uses lsci_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsci_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                job_valid,
    input  wire lsci_pkg::lsci_job_t job,
    output logic                     job_done,
    input  wire logic                pop,
    output logic                     empty,
    output logic [1:0]               bus_kind,
    output logic [1:0]               enable_mask,
    output logic [7:0]               bus_byte,
    output logic [7:0]               contrast_duty,
    output logic [7:0]               backlight_duty,
    output logic                     last_of_run
);

    logic [3:0] idx_reg;
    logic       out_valid_reg;
    logic [1:0] kind_reg;
    logic [1:0] mask_reg;
    logic [7:0] byte_reg;
    logic [7:0] contrast_reg;
    logic [7:0] backlight_reg;
    logic       last_reg;
    logic       out_free;
    logic       issue;
    logic       is_last;

    assign out_free = !out_valid_reg || pop;
    assign issue    = job_valid && out_free;
    assign is_last  = (idx_reg == job.count - 4'd1);
    assign job_done = issue && is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                idx_reg       <= is_last ? 4'd0 : idx_reg + 4'd1;
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            kind_reg      <= (idx_reg == 4'd0) ? job.first_kind : lsci_pkg::KIND_DATA;
            mask_reg      <= job.mask;
            byte_reg      <= job.data[idx_reg];
            contrast_reg  <= job.contrast;
            backlight_reg <= job.backlight;
            last_reg      <= is_last;
        end
    end

    assign empty          = !out_valid_reg;
    assign bus_kind       = kind_reg;
    assign enable_mask    = mask_reg;
    assign bus_byte       = byte_reg;
    assign contrast_duty  = contrast_reg;
    assign backlight_duty = backlight_reg;
    assign last_of_run    = last_reg;

endmodule

`default_nettype wire

@@ hw/rtl/lcd_serial_command_interpreter.sv @@
// A job word is queued for each accepted byte; its bus words go to the output
// register. Throughput: one bus word per cycle while pop keeps that register
// free; a byte yields 1 to 9 bus words (glyph 9, brightness 2, others 1).
// QUEUE_DEPTH jobs can wait between parser and output; full while they do.
// Reset: async active low; queue empty, parser idle, PWM levels to defaults.
// Glyph buffer is not reset. Depends on lsci_pkg, lsci_front/queue/back.
`timescale 1ns / 1ps
`default_nettype none

module lcd_serial_command_interpreter #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] rx_byte,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data,
    output logic            empty,
    input  wire logic       pop,
    output logic [1:0]      bus_kind,
    output logic [1:0]      enable_mask,
    output logic [7:0]      bus_byte,
    output logic [7:0]      contrast_duty,
    output logic [7:0]      backlight_duty,
    output logic            last_of_run
);

    lsci_pkg::lsci_job_t front_job;
    lsci_pkg::lsci_job_t head_job;
    logic accept;
    logic head_valid;
    logic head_done;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    lsci_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .rx_byte  (rx_byte),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .job      (front_job)
    );

    lsci_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept),
        .wr_job   (front_job),
        .full     (full),
        .rd_en    (head_done),
        .rd_valid (head_valid),
        .rd_job   (head_job)
    );

    lsci_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .job_valid      (head_valid),
        .job            (head_job),
        .job_done       (head_done),
        .pop            (pop),
        .empty          (empty),
        .bus_kind       (bus_kind),
        .enable_mask    (enable_mask),
        .bus_byte       (bus_byte),
        .contrast_duty  (contrast_duty),
        .backlight_duty (backlight_duty),
        .last_of_run    (last_of_run)
    );

endmodule

`default_nettype wire

@@ hw/rtl/lsci_checker.sv @@
// lsci_checker: port-level assertions for lcd_serial_command_interpreter,
// bound to the top level below. Uses lsci_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lsci_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [1:0] bus_kind,
    input wire logic [1:0] enable_mask,
    input wire logic [7:0] bus_byte,
    input wire logic [7:0] contrast_duty,
    input wire logic [7:0] backlight_duty,
    input wire logic       last_of_run
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(bus_byte) && $stable(bus_kind)
            && $stable(enable_mask) && $stable(last_of_run)))
        else $error("result word changed while stalled");

    a_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && bus_kind == lsci_pkg::KIND_NONE) |->
            (enable_mask == lsci_pkg::MASK_NONE && bus_byte == 8'd0 && last_of_run))
        else $error("no-write word not a lone zero word");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && bus_kind != lsci_pkg::KIND_NONE) |->
            ((bus_kind == lsci_pkg::KIND_INST || bus_kind == lsci_pkg::KIND_DATA)
             && enable_mask != lsci_pkg::MASK_NONE))
        else $error("bad bus kind or empty enable mask");

    a_run: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last_of_run) |=>
            (!empty && $stable(contrast_duty) && $stable(backlight_duty)
             && bus_kind == lsci_pkg::KIND_DATA))
        else $error("run broken or duties changed inside a run");

endmodule

bind lcd_serial_command_interpreter lsci_checker u_lsci_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .empty          (empty),
    .pop            (pop),
    .bus_kind       (bus_kind),
    .enable_mask    (enable_mask),
    .bus_byte       (bus_byte),
    .contrast_duty  (contrast_duty),
    .backlight_duty (backlight_duty),
    .last_of_run    (last_of_run)
);

`default_nettype wire

@@ tb/lcd_serial_command_interpreter_tb.sv @@
// Self-checking testbench for lcd_serial_command_interpreter: queue-fed byte driver,
// bus word monitor and an in-bench command parser model that predicts every bus word.
// Depends on lsci_pkg and the lcd_serial_command_interpreter RTL.
`timescale 1ns / 1ps

module lcd_serial_command_interpreter_tb;
    import lsci_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RX_HOLD_CYCLES = 250;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TIMEOUT_NS     = 4_000_000;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] mask;
        logic [7:0] data;
        logic [7:0] contrast;
        logic [7:0] backlight;
        logic       last;
    } bus_word_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       push      = 1'b0;
    logic [7:0] rx_byte   = 8'd0;
    logic       cfg_valid = 1'b0;
    logic [7:0] cfg_data  = 8'd0;
    logic       pop       = 1'b0;
    logic       full;
    logic       cfg_ready;
    logic       empty;
    logic [1:0] bus_kind;
    logic [1:0] enable_mask;
    logic [7:0] bus_byte;
    logic [7:0] contrast_duty;
    logic [7:0] backlight_duty;
    logic       last_of_run;

    // parser model state
    lsci_state_t parse_st      = ST_IDLE;
    logic [1:0]  target        = MASK_UPPER;
    logic [7:0]  cursor        = 8'd0;
    logic [7:0]  col_latch     = 8'd0;
    logic [7:0]  contrast_lvl  = CONTRAST_RESET;
    logic [7:0]  backlight_lvl = BACKLIGHT_RESET;
    logic [7:0]  bl_on_level   = BL_ON_RESET;
    logic [7:0]  glyph [8];
    bus_word_t   run_buf [JOB_WORDS];
    int          run_len;

    logic [7:0] rx_pending_q [$];
    logic [7:0] bl_on_writes_q [$];
    bus_word_t  bus_words_q [$];

    int send_idle_pct = 31;
    int recv_idle_pct = 78;
    bit sender_hold   = 1'b0;
    bit rx_hold_req   = 1'b0;
    bit rx_hold_ack   = 1'b0;
    int rx_hold_left  = 0;
    int bytes_queued  = 0;
    int mismatches    = 0;

    lcd_serial_command_interpreter dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .rx_byte        (rx_byte),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .empty          (empty),
        .pop            (pop),
        .bus_kind       (bus_kind),
        .enable_mask    (enable_mask),
        .bus_byte       (bus_byte),
        .contrast_duty  (contrast_duty),
        .backlight_duty (backlight_duty),
        .last_of_run    (last_of_run)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("lcd_serial_command_interpreter_tb failed");
        $finish;
    end

    task automatic add_bus_write(input logic [1:0] kind, input logic [1:0] mask,
                                 input logic [7:0] data);
        run_buf[run_len] = '{kind, mask, data, 8'd0, 8'd0, 1'b0};
        run_len++;
    endtask

    task automatic interpret_byte(input logic [7:0] b);
        lsci_state_t st;
        logic [7:0]  addr;
        st = parse_st;
        run_len = 0;
        case (st)
            ST_IDLE:
            begin
                if (b != PREFIX_BYTE)
                    add_bus_write(KIND_DATA, target, b);
                else
                    parse_st = ST_CMD;
            end
            ST_CMD:
            begin
                parse_st = ST_IDLE;
                case (b)
                    CMD_HOME, CMD_CLEAR:
                    begin
                        target = MASK_UPPER;
                        add_bus_write(KIND_INST, MASK_UPPER, HOME_ADDR);
                    end
                    CMD_BL_ON:
                    begin
                        backlight_lvl = bl_on_level;
                        parse_st = ST_SKIP1;
                    end
                    CMD_BL_OFF:                   backlight_lvl = BACKLIGHT_OFF;
                    CMD_GOTO:                     parse_st = ST_COL;
                    CMD_GLYPH:                    parse_st = ST_GLYPH_0;
                    CMD_CONTRAST, CMD_CONTRAST_ALT: parse_st = ST_CONTRAST;
                    CMD_GPO_OFF, CMD_GPO_ON:      parse_st = ST_SKIP1;
                    CMD_GPO_PWM:                  parse_st = ST_SKIP2;
                    CMD_BRIGHT, CMD_BRIGHT_ALT:   parse_st = ST_BRIGHT;
                    default:                      ;
                endcase
            end
            ST_COL:
            begin
                col_latch = b;
                parse_st = ST_ROW;
            end
            ST_ROW:
            begin
                case (b)
                    ROW_1:
                    begin
                        cursor = ROW_BASE_ODD;
                        target = MASK_UPPER;
                    end
                    ROW_2:
                    begin
                        cursor = ROW_BASE_EVEN;
                        target = MASK_UPPER;
                    end
                    ROW_3:
                    begin
                        cursor = ROW_BASE_ODD;
                        target = MASK_LOWER;
                    end
                    ROW_4:
                    begin
                        cursor = ROW_BASE_EVEN;
                        target = MASK_LOWER;
                    end
                    default: ;
                endcase
                cursor = cursor + col_latch;
                add_bus_write(KIND_INST, target, cursor);
                parse_st = ST_IDLE;
            end
            ST_GLYPH_0, ST_GLYPH_1, ST_GLYPH_2, ST_GLYPH_3,
            ST_GLYPH_4, ST_GLYPH_5, ST_GLYPH_6, ST_GLYPH_7:
            begin
                glyph[3'(st - ST_GLYPH_0)] = b;
                parse_st = lsci_state_t'(st + 5'd1);
            end
            ST_GLYPH_LAST:
            begin
                addr = CGRAM_BASE + {glyph[0][4:0], 3'b000};
                add_bus_write(KIND_INST, MASK_BOTH, addr);
                for (int i = 1; i < 8; i++)
                    add_bus_write(KIND_DATA, MASK_BOTH, glyph[i]);
                add_bus_write(KIND_DATA, MASK_BOTH, b);
                parse_st = ST_IDLE;
            end
            ST_CONTRAST:
            begin
                contrast_lvl = 8'hFF - b;
                parse_st = ST_IDLE;
            end
            ST_BRIGHT:
            begin
                backlight_lvl = b;
                add_bus_write(KIND_INST, MASK_BOTH, FUNCTION_SET);
                add_bus_write(KIND_DATA, MASK_BOTH, 8'd3 - (b >> 6));
                parse_st = ST_IDLE;
            end
            ST_SKIP2: parse_st = ST_SKIP1;
            default:  parse_st = ST_IDLE;
        endcase
        if (run_len == 0)
            add_bus_write(KIND_NONE, MASK_NONE, 8'd0);
        for (int i = 0; i < run_len; i++)
        begin
            run_buf[i].contrast  = contrast_lvl;
            run_buf[i].backlight = backlight_lvl;
            run_buf[i].last      = (i == run_len - 1);
            bus_words_q.push_back(run_buf[i]);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // byte driver
    always @(posedge clk)
    begin
        if (push && !full)
        begin
            interpret_byte(rx_byte);
            void'(rx_pending_q.pop_front());
        end
        if (!(push && full))
        begin
            if (rx_pending_q.size() != 0 && !sender_hold
                && $urandom_range(99) >= send_idle_pct)
            begin
                push    <= 1'b1;
                rx_byte <= rx_pending_q[0];
            end
            else
                push <= 1'b0;
        end
    end

    // backlight-on level writes
    always @(posedge clk)
    begin
        if (cfg_valid && cfg_ready)
            bl_on_level = cfg_data;
        if (!(cfg_valid && !cfg_ready))
        begin
            if (bl_on_writes_q.size() != 0)
            begin
                cfg_valid <= 1'b1;
                cfg_data  <= bl_on_writes_q.pop_front();
            end
            else
                cfg_valid <= 1'b0;
        end
    end

    // bus word monitor
    always @(posedge clk)
    begin : monitor
        bus_word_t w;
        if (pop && !empty)
        begin
            if (bus_words_q.size() == 0)
            begin
                $error("bus word with nothing expected: kind %0d byte %0d",
                       bus_kind, bus_byte);
                mismatches++;
            end
            else
            begin
                w = bus_words_q.pop_front();
                check_field("bus_kind", w.kind, bus_kind);
                check_field("enable_mask", w.mask, enable_mask);
                check_field("bus_byte", w.data, bus_byte);
                check_field("contrast_duty", w.contrast, contrast_duty);
                check_field("backlight_duty", w.backlight, backlight_duty);
                check_field("last_of_run", w.last, last_of_run);
            end
        end
        if (rx_hold_req != rx_hold_ack)
        begin
            rx_hold_ack  = rx_hold_req;
            rx_hold_left = RX_HOLD_CYCLES;
        end
        if (rx_hold_left != 0)
        begin
            rx_hold_left--;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic queue_byte(input logic [7:0] b);
        rx_pending_q.push_back(b);
        bytes_queued++;
    endtask

    function automatic logic [7:0] rand_arg();
        if ($urandom_range(4) == 0)
            return $urandom_range(1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(255));
    endfunction

    task automatic queue_random_sequence();
        int         sel;
        logic [7:0] b;
        sel = $urandom_range(99);
        if (sel < 30)
        begin
            b = 8'($urandom_range(255));
            if (b == PREFIX_BYTE)
                b = 8'($urandom_range(253));
            queue_byte(b);
        end
        else if (sel < 90)
        begin
            queue_byte(PREFIX_BYTE);
            case ($urandom_range(14))
                0:
                begin
                    queue_byte(CMD_BL_ON);
                    queue_byte(rand_arg());
                end
                1: queue_byte(CMD_BL_OFF);
                2:
                begin
                    queue_byte(CMD_GOTO);
                    queue_byte(rand_arg());
                    if ($urandom_range(7) == 0)
                        queue_byte(rand_arg());
                    else
                        queue_byte(8'($urandom_range(4, 1)));
                end
                3: queue_byte(CMD_HOME);
                4: queue_byte(CMD_CLEAR);
                5, 14:
                begin
                    queue_byte(CMD_GLYPH);
                    for (int i = 0; i < 9; i++)
                        queue_byte(rand_arg());
                end
                6, 7:
                begin
                    queue_byte(sel[0] ? CMD_CONTRAST : CMD_CONTRAST_ALT);
                    queue_byte(rand_arg());
                end
                8, 9:
                begin
                    queue_byte(sel[0] ? CMD_GPO_OFF : CMD_GPO_ON);
                    queue_byte(rand_arg());
                end
                10:
                begin
                    queue_byte(CMD_GPO_PWM);
                    queue_byte(rand_arg());
                    queue_byte(rand_arg());
                end
                11, 12:
                begin
                    queue_byte(sel[0] ? CMD_BRIGHT : CMD_BRIGHT_ALT);
                    queue_byte(rand_arg());
                end
                default:
                begin
                    b = 8'($urandom_range(255));
                    case (b)
                        CMD_BL_ON, CMD_BL_OFF, CMD_GOTO, CMD_HOME, CMD_GLYPH, CMD_CONTRAST,
                        CMD_GPO_OFF, CMD_GPO_ON, CMD_CLEAR, CMD_GPO_PWM, CMD_CONTRAST_ALT,
                        CMD_BRIGHT, CMD_BRIGHT_ALT:
                            b = PREFIX_BYTE;
                        default: ;
                    endcase
                    queue_byte(b);
                end
            endcase
        end
        else
            queue_byte($urandom_range(1) ? PREFIX_BYTE : 8'($urandom_range(255)));
    endtask

    task automatic feed_random(input int n_bytes);
        int start;
        start = bytes_queued;
        while (bytes_queued - start < n_bytes)
            queue_random_sequence();
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (rx_pending_q.size() != 0 || push || bus_words_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_bl_on_level(input logic [7:0] value);
        bl_on_writes_q.push_back(value);
        do @(negedge clk);
        while (bl_on_writes_q.size() != 0 || cfg_valid);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset duties, extreme chars, goto wrap, bad row, unknown cmd, duties
        queue_byte(8'h00); queue_byte(8'hFF);
        queue_byte(PREFIX_BYTE); queue_byte(CMD_GOTO); queue_byte(8'hFF); queue_byte(ROW_4);
        queue_byte(PREFIX_BYTE); queue_byte(CMD_GOTO); queue_byte(8'h01); queue_byte(8'h00);
        queue_byte(PREFIX_BYTE); queue_byte(PREFIX_BYTE);
        queue_byte(PREFIX_BYTE); queue_byte(CMD_BRIGHT); queue_byte(8'hFF);
        queue_byte(PREFIX_BYTE); queue_byte(CMD_CONTRAST); queue_byte(8'h00);
        queue_byte(PREFIX_BYTE); queue_byte(CMD_BL_OFF);
        queue_byte(PREFIX_BYTE); queue_byte(CMD_BL_ON); queue_byte(8'h00);
        queue_byte(PREFIX_BYTE); queue_byte(CMD_CLEAR);
        wait_drained();

        write_bl_on_level(8'hFF);
        feed_random(85);
        do @(negedge clk);
        while (rx_pending_q.size() > 40);
        sender_hold = 1'b1;
        do @(negedge clk);
        while (push || bus_words_q.size() != 0);
        sender_hold = 1'b0;
        wait_drained();

        send_idle_pct = 78;
        recv_idle_pct = 31;
        write_bl_on_level(8'h00);
        feed_random(85);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_bl_on_level(8'($urandom_range(254, 1)));
        rx_hold_req = ~rx_hold_req;
        feed_random(85);
        wait_drained();

        if (mismatches == 0)
            $display("lcd_serial_command_interpreter_tb passed");
        else
            $display("lcd_serial_command_interpreter_tb failed");
        $finish;
    end

endmodule
